// ===== rtl/core/trs_pkg.sv =====
// trs_pkg: shared types and constants for the totient range sum block
// sequencer state encoding and the saturation limit of the running sum
// no dependencies
package trs_pkg;

	localparam int unsigned SUM_WIDTH = 32;
	localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CHECK,
		ST_MOD,
		ST_RES,
		ST_STRIP,
		ST_FINAL,
		ST_LAST,
		ST_ACCUM,
		ST_DONE
	} trs_state_t;

endpackage

// ===== rtl/core/trs_div.sv =====
// trs_div: restoring divider, one quotient bit per cycle
// gives quotient and remainder together; standalone, no package use
module trs_div #(
	parameter int unsigned W = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);

	localparam int unsigned CW = $clog2(W);

	logic          active_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  div_q;

	logic [W:0]    rem_shift;
	logic [W:0]    diff;
	logic          q_bit;

	always_comb begin
		rem_shift = {rem_q, quo_q[W-1]};
		diff      = rem_shift - {1'b0, div_q};
		q_bit     = ~diff[W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (active_q) begin
			rem_q <= q_bit ? diff[W-1:0] : rem_shift[W-1:0];
			quo_q <= {quo_q[W-2:0], q_bit};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/core/totient_range_sum.sv =====
// totient_range_sum: top level, sequencer around one shared divider
// depends on trs_pkg and trs_div
//
// usage
// - command channel: drive range_low/range_high and raise start; the item is
//   taken at the rising edge where start is high and busy is low
// - busy rises at the accepting edge and stays high through the strobe cycle;
//   the next item can be taken at the edge after the one that ends the strobe
// - result channel: valid is high for exactly one cycle with totient_sum;
//   the receiver must take it then, it cannot hold the block off
// - both bounds are cut to VALUE_WIDTH bits (at most 16) before use
// - for each n in the range the block factors n by trial division, each
//   trial being one pass through the shared W-bit divider (W = bound width)
// - per n: a load step, one division for every trial divisor p with
//   p*p <= rest, one for each strip, update and leftover-factor division,
//   the last check, the final test and the accumulate; n of 0 or 1 goes
//   straight from load to accumulate
// - an empty range (low > high) strobes 0 in the cycle right after acceptance
// - the sum saturates at all ones, which cannot happen at 16-bit bounds
// - the divider sets the rate: everything waits on its one bit per cycle
// - reset (arst_n low) drops busy and valid at once; any item in flight is lost
module totient_range_sum
	import trs_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [15:0]          range_low,
	input  logic [15:0]          range_high,
	output logic                 busy,
	output logic                 valid,
	output logic [SUM_WIDTH-1:0] totient_sum
);

	// inputs are 16 bits wide, so a wider setting changes nothing
	localparam int unsigned W = (VALUE_WIDTH < 16) ? VALUE_WIDTH : 16;
	// p*p stays below 2^W + 2^(W/2+1) + 1
	localparam int unsigned PW = W + 2;

	trs_state_t state_q, state_d;

	logic [W-1:0]         lo_w, hi_w;
	logic [W-1:0]         n_q, hi_q;
	logic [W-1:0]         rest_q;
	logic [W-1:0]         res_q;
	logic [W-1:0]         p_q;
	logic [PW-1:0]        psq_q;
	logic [SUM_WIDTH-1:0] sum_q;

	// divider hookup
	logic                 div_start;
	logic [W-1:0]         div_a, div_b;
	logic                 div_done;
	logic [W-1:0]         div_quot, div_rem;

	logic [SUM_WIDTH:0]   sum_ext;
	logic                 sum_sat;

	assign lo_w = range_low[W-1:0];
	assign hi_w = range_high[W-1:0];

	assign sum_ext = {1'b0, sum_q} + (SUM_WIDTH + 1)'(res_q);
	assign sum_sat = (sum_ext >= {1'b0, SUM_MAX});

	trs_div #(.W(W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and divider requests
	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_a     = rest_q;
		div_b     = p_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (lo_w > hi_w) ? ST_DONE : ST_LOAD;
				end
			end
			ST_LOAD: begin
				// zero and one contribute nothing
				state_d = (n_q < W'(2)) ? ST_ACCUM : ST_CHECK;
			end
			ST_CHECK: begin
				if (psq_q > PW'(rest_q)) begin
					state_d = ST_FINAL;
				end else begin
					div_start = 1'b1;
					state_d   = ST_MOD;
				end
			end
			ST_MOD: begin
				if (div_done) begin
					if (div_rem != '0) begin
						state_d = ST_CHECK;
					end else begin
						// p divides rest: take res / p next
						div_start = 1'b1;
						div_a     = res_q;
						state_d   = ST_RES;
					end
				end
			end
			ST_RES: begin
				if (div_done) begin
					div_start = 1'b1;
					state_d   = ST_STRIP;
				end
			end
			ST_STRIP: begin
				if (div_done) begin
					if (div_rem == '0) begin
						div_start = 1'b1;
						div_a     = div_quot;
					end else begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_FINAL: begin
				if (rest_q > W'(1)) begin
					// leftover prime factor
					div_start = 1'b1;
					div_a     = res_q;
					div_b     = rest_q;
					state_d   = ST_LAST;
				end else begin
					state_d = ST_ACCUM;
				end
			end
			ST_LAST: begin
				if (div_done) begin
					state_d = ST_ACCUM;
				end
			end
			ST_ACCUM: begin
				state_d = (sum_sat || n_q == hi_q) ? ST_DONE : ST_LOAD;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				n_q   <= lo_w;
				hi_q  <= hi_w;
				sum_q <= '0;
			end
			ST_LOAD: begin
				rest_q <= n_q;
				res_q  <= (n_q < W'(2)) ? '0 : n_q;
				p_q    <= W'(2);
				psq_q  <= PW'(4);
			end
			ST_MOD: begin
				if (div_done && div_rem != '0) begin
					psq_q <= psq_q + PW'({p_q, 1'b1});
					p_q   <= p_q + 1'b1;
				end
			end
			ST_RES: begin
				if (div_done) begin
					res_q <= res_q - div_quot;
				end
			end
			ST_STRIP: begin
				if (div_done) begin
					if (div_rem == '0) begin
						rest_q <= div_quot;
					end else begin
						psq_q <= psq_q + PW'({p_q, 1'b1});
						p_q   <= p_q + 1'b1;
					end
				end
			end
			ST_LAST: begin
				if (div_done) begin
					res_q <= res_q - div_quot;
				end
			end
			ST_ACCUM: begin
				sum_q <= sum_sat ? SUM_MAX : sum_ext[SUM_WIDTH-1:0];
				n_q   <= n_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign busy        = (state_q != ST_IDLE);
	assign valid       = (state_q == ST_DONE);
	assign totient_sum = sum_q;

endmodule

// ===== rtl/core/trs_checker.sv =====
// trs_checker: port-level checks on the totient range sum block
// bound to totient_range_sum; uses trs_pkg for the sum width
module trs_checker
	import trs_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input logic                 valid,
	input logic [SUM_WIDTH-1:0] totient_sum
);

	// a result only comes out of a running item
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> busy)
		else $error("result strobe while idle");

	// one result per item, then ready again
	a_valid_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		valid |=> (!valid && !busy))
		else $error("result strobe not a single cycle or block stays busy");

	// an accepted item makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("item accepted but block not busy");

	// busy only rises on an accepted item
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a start");

	// result value stays known when shown
	a_sum_known: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> !$isunknown(totient_sum))
		else $error("unknown result value");

endmodule

bind totient_range_sum trs_checker u_trs_checker (.*);
